/* rtl/bgd_pkg.sv */
package bgd_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int EV_W       = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd4;

	localparam logic [EV_W-1:0] EV_PRESSED = 3'd0;
	localparam logic [EV_W-1:0] EV_SHORT   = 3'd1;
	localparam logic [EV_W-1:0] EV_LONG    = 3'd2;
	localparam logic [EV_W-1:0] EV_HOLD    = 3'd3;
	localparam logic [EV_W-1:0] EV_DOUBLE  = 3'd4;

	localparam logic [7:0]  DEBOUNCE_RST = 8'd20;
	localparam logic [15:0] SHORT_RST    = 16'd300;
	localparam logic [15:0] LONG_RST     = 16'd1000;
	localparam logic [15:0] HOLD_RST     = 16'd5000;
	localparam logic [15:0] WINDOW_RST   = 16'd400;

	typedef struct packed {
		logic            valid;
		logic [EV_W-1:0] code;
	} bgd_res_t;

endpackage

/* rtl/bgd_core.sv */
module bgd_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic                            level,
	input  logic                            cfg_we,
	input  logic [bgd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bgd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output bgd_pkg::bgd_res_t               res
);
	import bgd_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [CMP_W-1:0] CNT_MAX_EXT = CMP_W'(CNT_MAX);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CONF,
		PH_WIN
	} phase_t;

	logic [7:0]             debounce_q;
	logic [15:0]            short_q;
	logic [15:0]            long_q;
	logic [15:0]            hold_q;
	logic [15:0]            window_len_q;

	phase_t                 phase_q, phase_n;
	logic                   last_level_q, dpend_q, dpend_n;
	logic                   drun_q, drun_n, lrep_q, lrep_n, hrep_q, hrep_n;
	logic [COUNT_WIDTH-1:0] press_q, press_n, conf_q, conf_n, win_q, win_n;
	logic [COUNT_WIDTH-1:0] win_load;
	logic [CMP_W-1:0]       window_ext;
	bgd_res_t               res_n;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
	endfunction

	assign window_ext = CMP_W'(window_len_q);
	assign win_load   = (window_ext > CNT_MAX_EXT) ? CNT_MAX : COUNT_WIDTH'(window_len_q);

	always_comb begin
		phase_n = phase_q;
		dpend_n = dpend_q;
		drun_n  = drun_q;
		lrep_n  = lrep_q;
		hrep_n  = hrep_q;
		press_n = press_q;
		conf_n  = conf_q;
		win_n   = win_q;
		res_n   = '{valid: 1'b0, code: EV_PRESSED};
		if (!level) begin
			if (last_level_q) begin
				press_n = '0;
				drun_n  = 1'b1;
				lrep_n  = 1'b0;
				hrep_n  = 1'b0;
				if (phase_q == PH_WIN)
					dpend_n = 1'b1;
				phase_n = PH_IDLE;
				win_n   = '0;
			end else begin
				press_n = sat_inc(press_q);
				if (phase_q == PH_CONF)
					conf_n = sat_inc(conf_q);
			end
			if (drun_n && CMP_W'(press_n) >= CMP_W'(debounce_q)) begin
				drun_n  = 1'b0;
				phase_n = PH_CONF;
				conf_n  = '0;
				lrep_n  = 1'b0;
				hrep_n  = 1'b0;
				res_n   = '{valid: 1'b1, code: EV_PRESSED};
			end else if (phase_n == PH_CONF) begin
				// long wins when both thresholds are met; hold follows next tick
				if (!lrep_n && CMP_W'(conf_n) >= CMP_W'(long_q)) begin
					lrep_n = 1'b1;
					res_n  = '{valid: 1'b1, code: EV_LONG};
				end else if (!hrep_n && CMP_W'(conf_n) >= CMP_W'(hold_q)) begin
					hrep_n = 1'b1;
					res_n  = '{valid: 1'b1, code: EV_HOLD};
				end
			end
		end else if (!last_level_q) begin
			press_n = sat_inc(press_q);
			drun_n  = 1'b0;
			// a bounce leaves phase and the pending double untouched
			if (CMP_W'(press_n) >= CMP_W'(debounce_q)) begin
				if (dpend_q) begin
					dpend_n = 1'b0;
					phase_n = PH_IDLE;
					win_n   = '0;
					res_n   = '{valid: 1'b1, code: EV_DOUBLE};
				end else if (CMP_W'(press_n) < CMP_W'(short_q)) begin
					phase_n = PH_WIN;
					win_n   = win_load;
				end else begin
					phase_n = PH_IDLE;
					res_n   = '{valid: 1'b1, code: EV_SHORT};
				end
			end
		end else if (phase_q == PH_WIN) begin
			if (win_q <= COUNT_WIDTH'(1)) begin
				win_n   = '0;
				phase_n = PH_IDLE;
				res_n   = '{valid: 1'b1, code: EV_SHORT};
			end else begin
				win_n = win_q - COUNT_WIDTH'(1);
			end
		end
	end

	assign res = '{valid: take && res_n.valid, code: res_n.code};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			short_q      <= SHORT_RST;
			long_q       <= LONG_RST;
			hold_q       <= HOLD_RST;
			window_len_q <= WINDOW_RST;
			phase_q      <= PH_IDLE;
			last_level_q <= 1'b1;
			dpend_q      <= 1'b0;
			drun_q       <= 1'b0;
			lrep_q       <= 1'b0;
			hrep_q       <= 1'b0;
			press_q      <= '0;
			conf_q       <= '0;
			win_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DEBOUNCE: debounce_q   <= cfg_data[7:0];
					REG_SHORT:    short_q      <= cfg_data;
					REG_LONG:     long_q       <= cfg_data;
					REG_HOLD:     hold_q       <= cfg_data;
					REG_WINDOW:   window_len_q <= cfg_data;
					default:      ;
				endcase
			end
			if (take) begin
				phase_q      <= phase_n;
				last_level_q <= level;
				dpend_q      <= dpend_n;
				drun_q       <= drun_n;
				lrep_q       <= lrep_n;
				hrep_q       <= hrep_n;
				press_q      <= press_n;
				conf_q       <= conf_n;
				win_q        <= win_n;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_conf_no_debounce: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CONF |-> !drun_q)
		else $error("debounce still running in confirmed phase");

	a_window_only_open: assert property (@(posedge clk) disable iff (!arst_n)
		win_q != '0 |-> phase_q == PH_WIN)
		else $error("window count live outside window phase");
`endif

endmodule

/* rtl/button_gesture_detector.sv */
// Button gesture detector: debounced press, short, long, hold and double click.
// Input channel (in_valid, in_stall, level): one pin sample per tick, 0 pressed.
// Output channel (out_valid, out_stall, event_res): 0 pressed, 1 short, 2 long,
// 3 hold, 4 double click; a sample yields zero or one event.
// Throughput is one sample per cycle while in_stall is low: the whole gesture
// state advances in one registered step per accepted request. A sample's event
// is registered in the output register, or in the skid register if output stalls.
// When the receiver stalls, the output holds and one more event is caught in a
// skid register; in_stall rises only while that skid register is full, so
// samples that cause no event keep flowing until then.
// Configuration (cfg_we, cfg_index, cfg_data) writes the five timing registers
// in ticks: debounce, short, long, hold and double window; write only while idle.
// Reset restores the default timings (20, 300, 1000, 5000, 400), takes the pin
// as released, clears all counters and drops any pending event.
// COUNT_WIDTH sets the width of the saturating tick counters.
module button_gesture_detector #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            level,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bgd_pkg::EV_W-1:0]        event_res,
	input  logic                            cfg_we,
	input  logic [bgd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bgd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bgd_pkg::*;

	logic            take, pop;
	bgd_res_t        res;
	logic            out_valid_q, skid_valid_q;
	logic [EV_W-1:0] event_q, skid_q;

	assign in_stall = skid_valid_q;
	assign take     = in_valid && !skid_valid_q;
	assign pop      = out_valid_q && !out_stall;

	bgd_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.level     (level),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			priority if (pop) begin
				// refill from skid first; no new request arrives while it is full
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= res.valid;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= res.valid;
			end else if (res.valid) begin
				skid_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= skid_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q)
			event_q <= skid_q;
		else if ((pop || !out_valid_q) && res.valid)
			event_q <= res.code;
		if (!pop && out_valid_q && res.valid)
			skid_q <= res.code;
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds an event while output is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid filled without a stalled output");

	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res <= EV_DOUBLE)
		else $error("undefined event code on output");
`endif

endmodule
